// ===== hdl/lgrs_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package lgrs_pkg;

  localparam int unsigned ROW_W        = 64;
  localparam int unsigned IDX_W        = 12;
  localparam int unsigned CFG_WIDTH_W  = 7;
  localparam int unsigned CFG_HEIGHT_W = 13;
  localparam int unsigned CFG_DATA_W   = 13;
  localparam int unsigned CFG_IDX_W    = 1;
  localparam int unsigned FIFO_DEPTH   = 4;
  localparam int unsigned FIFO_PTR_W   = 2;
  localparam int unsigned FIFO_CNT_W   = 3;

  localparam logic [CFG_WIDTH_W-1:0]  WIDTH_RESET  = 7'd16;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_RESET = 13'd16;
  localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH  = 1'b0,
    REG_GRID_HEIGHT = 1'b1
  } cfg_reg_e;

  // One result word as it leaves the block.
  typedef struct packed {
    logic [ROW_W-1:0] cells;
    logic [IDX_W-1:0] idx;
    logic             changed;
    logic             last;
  } res_t;

  // Change flags after the first and after the second result of an item.
  typedef struct packed {
    logic a;
    logic b;
  } chg_t;

endpackage

`default_nettype wire

// ===== hdl/lgrs_lane.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgrs_lane
  import lgrs_pkg::*;
(
  input  wire logic [2:0] up_i,
  input  wire logic [2:0] mid_i,
  input  wire logic [2:0] down_i,
  output logic            next_o
);

  logic [3:0] ncount;

  // Bit 1 of each window is the lane's own column; the center is not a neighbor.
  assign ncount = 4'(up_i[0]) + 4'(up_i[1]) + 4'(up_i[2])
                + 4'(mid_i[0]) + 4'(mid_i[2])
                + 4'(down_i[0]) + 4'(down_i[1]) + 4'(down_i[2]);

  assign next_o = (ncount == 4'd3) || (mid_i[1] && (ncount == 4'd2));

endmodule

`default_nettype wire

// ===== hdl/lgrs_merge.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgrs_merge
  import lgrs_pkg::*;
#(
  parameter int unsigned LANES = 64
) (
  input  wire logic [LANES-1:0]        next_a_i,
  input  wire logic [LANES-1:0]        cur_a_i,
  input  wire logic [LANES-1:0]        next_b_i,
  input  wire logic [LANES-1:0]        cur_b_i,
  input  wire logic                    emit_a_i,
  input  wire logic                    emit_b_i,
  input  wire logic                    change_seen_i,
  input  wire logic [CFG_HEIGHT_W-1:0] rows_seen_i,
  output chg_t                         chg_o,
  output res_t                         first_o,
  output res_t                         second_o,
  output logic [1:0]                   push_n_o
);

  res_t res_a;
  res_t res_b;

  // The flag is sticky, so the second result sees what the first one found.
  assign chg_o.a = change_seen_i || (emit_a_i && (next_a_i != cur_a_i));
  assign chg_o.b = chg_o.a || (next_b_i != cur_b_i);

  always_comb begin
    res_a.cells   = ROW_W'(next_a_i);
    res_a.idx     = IDX_W'(rows_seen_i - 13'd1);
    res_a.changed = chg_o.a;
    res_a.last    = 1'b0;
    res_b.cells   = ROW_W'(next_b_i);
    res_b.idx     = rows_seen_i[IDX_W-1:0];
    res_b.changed = chg_o.b;
    res_b.last    = 1'b1;
  end

  assign first_o  = emit_a_i ? res_a : res_b;
  assign second_o = res_b;
  assign push_n_o = 2'(emit_a_i) + 2'(emit_b_i);

endmodule

`default_nettype wire

// ===== hdl/lgrs_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

module lgrs_fifo
  import lgrs_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic [1:0] push_n_i,
  input  wire res_t       first_i,
  input  wire res_t       second_i,
  output logic            space_o,
  output logic            valid_o,
  input  wire logic       ready_i,
  output res_t            data_o
);

  res_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wptr_q, wptr_d;
  logic [FIFO_PTR_W-1:0] rptr_q, rptr_d;
  logic [FIFO_CNT_W-1:0] count_q, count_d;
  logic [FIFO_PTR_W-1:0] wptr_next;
  logic                  pop;

  assign valid_o   = (count_q != '0);
  assign data_o    = mem_q[rptr_q];
  assign pop       = valid_o && ready_i;
  // Room for the worst case of two words per item.
  assign space_o   = (count_q <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wptr_next = wptr_q + FIFO_PTR_W'(1);

  always_comb begin
    wptr_d  = wptr_q + FIFO_PTR_W'(push_n_i);
    rptr_d  = rptr_q + FIFO_PTR_W'(pop);
    count_d = count_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < FIFO_DEPTH; i++) begin
      if ((push_n_i != 2'd0) && (FIFO_PTR_W'(i) == wptr_q)) begin
        mem_q[i] <= first_i;
      end else if ((push_n_i == 2'd2) && (FIFO_PTR_W'(i) == wptr_next)) begin
        mem_q[i] <= second_i;
      end
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("output queue count above depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push_n_i != 2'd0) |-> space_o)
    else $error("output queue written without room");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_n_i != 2'd3)
    else $error("more than two words pushed for one item");

endmodule

`default_nettype wire

// ===== hdl/life_generation_row_stencil.sv =====
// Conway Life (birth on 3, survival on 2 or 3) stencil, one generation per
// pass over a non-wrapping grid, one row per input word, top row first.
// Input channel: in_valid_i / in_ready_o with row_cells_i; bit i is column i.
// Output channel: out_valid_o / out_ready_i with next_row_cells_o,
// row_index_o, changed_o and last_row_o.
// The row arriving as row k yields the next state of row k-1 (none for k = 0);
// the last row of the generation also yields row k, marked last, after it.
// Config: cfg_we_i writes cfg_data_i to grid_width (index 0) or grid_height
// (index 1) in the same cycle; write only while the block is idle.
// A word enters a four-entry output queue in the cycle its row is accepted
// and is offered from that registered queue after any earlier words. One row
// per cycle is taken while in_ready_o is high; the 2*MAX_WIDTH neighbor-count
// lanes finish within that cycle. in_ready_o is high while the queue has room
// for two words, so a stalled receiver stops input after the queue fills and
// nothing is lost. Reset clears the stored rows, the row counter and the
// change flag, empties the queue and sets width and height to 16.
`timescale 1ns / 1ps
`default_nettype none

module life_generation_row_stencil
  import lgrs_pkg::*;
#(
  parameter int unsigned MAX_WIDTH = 64
) (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  input  wire logic                  in_valid_i,
  output logic                       in_ready_o,
  input  wire logic [ROW_W-1:0]      row_cells_i,
  output logic                       out_valid_o,
  input  wire logic                  out_ready_i,
  output logic [ROW_W-1:0]           next_row_cells_o,
  output logic [IDX_W-1:0]           row_index_o,
  output logic                       changed_o,
  output logic                       last_row_o
);

  logic [CFG_WIDTH_W-1:0]  grid_width_q;
  logic [CFG_HEIGHT_W-1:0] grid_height_q;
  logic [MAX_WIDTH-1:0]    row_above_q, row_above_d;
  logic [MAX_WIDTH-1:0]    row_middle_q, row_middle_d;
  logic [CFG_HEIGHT_W-1:0] rows_seen_q, rows_seen_d;
  logic                    change_seen_q, change_seen_d;

  logic [CFG_WIDTH_W-1:0]  w_eff;
  logic [CFG_HEIGHT_W-1:0] h_eff;
  logic [MAX_WIDTH-1:0]    mask;
  logic [MAX_WIDTH-1:0]    up_m, mid_m, row_m;
  logic [MAX_WIDTH+1:0]    pad_up, pad_mid, pad_row;
  logic [MAX_WIDTH-1:0]    lane_a, lane_b;
  logic [MAX_WIDTH-1:0]    next_a, next_b;
  logic                    in_accept;
  logic                    emit_a;
  logic                    is_last;
  logic [1:0]              push_n;
  chg_t                    chg;
  res_t                    first_res, second_res, out_res;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q  <= WIDTH_RESET;
      grid_height_q <= HEIGHT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_GRID_WIDTH:  grid_width_q  <= cfg_data_i[CFG_WIDTH_W-1:0];
        REG_GRID_HEIGHT: grid_height_q <= cfg_data_i;
      endcase
    end
  end

  always_comb begin
    if (grid_width_q == '0) begin
      w_eff = CFG_WIDTH_W'(1);
    end else if (grid_width_q > CFG_WIDTH_W'(MAX_WIDTH)) begin
      w_eff = CFG_WIDTH_W'(MAX_WIDTH);
    end else begin
      w_eff = grid_width_q;
    end
    if (grid_height_q == '0) begin
      h_eff = CFG_HEIGHT_W'(1);
    end else if (grid_height_q > HEIGHT_LIMIT) begin
      h_eff = HEIGHT_LIMIT;
    end else begin
      h_eff = grid_height_q;
    end
  end

  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_mask
    assign mask[g] = (CFG_WIDTH_W'(g) < w_eff);
  end

  assign in_accept = in_valid_i && in_ready_o;
  assign emit_a    = (rows_seen_q != '0);
  assign is_last   = ({1'b0, rows_seen_q} + 14'd1) >= {1'b0, h_eff};

  // Stored rows are masked again in case the width changed since they came in.
  assign row_m = row_cells_i[MAX_WIDTH-1:0] & mask;
  assign up_m  = (rows_seen_q >= CFG_HEIGHT_W'(2)) ? (row_above_q & mask) : '0;
  assign mid_m = emit_a ? (row_middle_q & mask) : '0;

  // Dead border on both sides of every row.
  assign pad_up  = {1'b0, up_m, 1'b0};
  assign pad_mid = {1'b0, mid_m, 1'b0};
  assign pad_row = {1'b0, row_m, 1'b0};

  for (genvar g = 0; g < MAX_WIDTH; g++) begin : g_lanes
    lgrs_lane u_lane_a (
      .up_i   (pad_up[g+2:g]),
      .mid_i  (pad_mid[g+2:g]),
      .down_i (pad_row[g+2:g]),
      .next_o (lane_a[g])
    );

    lgrs_lane u_lane_b (
      .up_i   (pad_mid[g+2:g]),
      .mid_i  (pad_row[g+2:g]),
      .down_i (3'b000),
      .next_o (lane_b[g])
    );
  end

  // Columns past the width may see live neighbors but stay dead.
  assign next_a = lane_a & mask;
  assign next_b = lane_b & mask;

  lgrs_merge #(
    .LANES (MAX_WIDTH)
  ) u_merge (
    .next_a_i      (next_a),
    .cur_a_i       (mid_m),
    .next_b_i      (next_b),
    .cur_b_i       (row_m),
    .emit_a_i      (emit_a && in_accept),
    .emit_b_i      (is_last && in_accept),
    .change_seen_i (change_seen_q),
    .rows_seen_i   (rows_seen_q),
    .chg_o         (chg),
    .first_o       (first_res),
    .second_o      (second_res),
    .push_n_o      (push_n)
  );

  always_comb begin
    row_above_d   = row_above_q;
    row_middle_d  = row_middle_q;
    rows_seen_d   = rows_seen_q;
    change_seen_d = change_seen_q;
    if (in_accept) begin
      if (is_last) begin
        row_above_d   = '0;
        row_middle_d  = '0;
        rows_seen_d   = '0;
        change_seen_d = 1'b0;
      end else begin
        row_above_d   = mid_m;
        row_middle_d  = row_m;
        rows_seen_d   = rows_seen_q + CFG_HEIGHT_W'(1);
        change_seen_d = chg.a;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_above_q   <= '0;
      row_middle_q  <= '0;
      rows_seen_q   <= '0;
      change_seen_q <= 1'b0;
    end else begin
      row_above_q   <= row_above_d;
      row_middle_q  <= row_middle_d;
      rows_seen_q   <= rows_seen_d;
      change_seen_q <= change_seen_d;
    end
  end

  lgrs_fifo u_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .first_i  (first_res),
    .second_i (second_res),
    .space_o  (in_ready_o),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_res)
  );

  assign next_row_cells_o = out_res.cells;
  assign row_index_o      = out_res.idx;
  assign changed_o        = out_res.changed;
  assign last_row_o       = out_res.last;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_accept && is_last) |=> ((rows_seen_q == '0) && !change_seen_q))
    else $error("generation state not cleared after the last row");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rows_seen_q < HEIGHT_LIMIT)
    else $error("row counter beyond the height limit");

endmodule

`default_nettype wire
